>>> rtl/bitmap_page_allocator_refcount_top_macros.svh
// Assertion helpers used by the allocator top module.
`ifndef BITMAP_PAGE_ALLOCATOR_REFCOUNT_TOP_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_REFCOUNT_TOP_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define BPAR_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bpar check failed");

// Checked at every rising clock edge, reset included.
`define BPAR_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bpar check failed");

`endif

>>> rtl/bpar_pkg.sv
package bpar_pkg;

  localparam int NUM_PAGES  = 32768;
  localparam int WORD_BITS  = 64;
  localparam int REF_BITS   = 16;
  localparam int MAP_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int WIDX_W     = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int STEP_W     = BIT_W + 1;
  localparam int CNT_W      = 16;
  localparam int LEN_W      = CNT_W + 1;
  localparam int PIDX_W     = 21;

  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  localparam logic [2:0] FN_INIT   = 3'd0;
  localparam logic [2:0] FN_ALLOC  = 3'd1;
  localparam logic [2:0] FN_FREE   = 3'd2;
  localparam logic [2:0] FN_INCREF = 3'd3;
  localparam logic [2:0] FN_QUERY  = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_MEM      = 3'd1;
  localparam logic [2:0] ST_BAD_COUNT   = 3'd2;
  localparam logic [2:0] ST_BAD_PAGE    = 3'd3;
  localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;
  localparam logic [2:0] ST_BAD_REF     = 3'd5;
  localparam logic [2:0] ST_NOT_ALLOC   = 3'd6;
  localparam logic [2:0] ST_OVERFLOW    = 3'd7;

  typedef struct packed {
    logic                map_we;
    logic [WIDX_W-1:0]   map_waddr;
    logic [BIT_W-1:0]    map_wbit;
    logic                map_wval;
    logic                ref_we;
    logic [PAGE_W-1:0]   ref_waddr;
    logic [REF_BITS-1:0] ref_wdata;
  } store_wr_t;

  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [STEP_W-1:0] step;
  } scan_res_t;

endpackage

>>> rtl/bpar_store.sv
module bpar_store (
  input  logic                                clk,
  input  bpar_pkg::store_wr_t                 wr,
  input  logic [bpar_pkg::WIDX_W-1:0]         map_raddr,
  output logic [bpar_pkg::WORD_BITS-1:0]      map_rdata,
  input  logic [bpar_pkg::PAGE_W-1:0]         ref_raddr,
  output logic [bpar_pkg::REF_BITS-1:0]       ref_rdata
);

  logic [bpar_pkg::WORD_BITS-1:0] map_mem [bpar_pkg::MAP_WORDS];
  logic [bpar_pkg::REF_BITS-1:0]  ref_mem [bpar_pkg::NUM_PAGES];

  // The bitmap is written one bit at a time through a bit enable.
  always_ff @(posedge clk) begin
    if (wr.map_we) begin
      map_mem[wr.map_waddr][wr.map_wbit] <= wr.map_wval;
    end
    map_rdata <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.ref_we) begin
      ref_mem[wr.ref_waddr] <= wr.ref_wdata;
    end
    ref_rdata <= ref_mem[ref_raddr];
  end

endmodule

>>> rtl/bpar_scan.sv
module bpar_scan (
  input  logic [bpar_pkg::WORD_BITS-1:0] word,
  input  logic [bpar_pkg::WIDX_W-1:0]    word_idx,
  input  logic [bpar_pkg::BIT_W-1:0]     bit_pos,
  input  logic [bpar_pkg::LEN_W-1:0]     run_len,
  input  logic [bpar_pkg::PAGE_W-1:0]    run_start,
  input  logic [bpar_pkg::CNT_W-1:0]     need,
  output bpar_pkg::scan_res_t            res
);

  logic                           is_free;
  logic [bpar_pkg::WORD_BITS-1:0] shifted;
  logic [bpar_pkg::WORD_BITS-1:0] probe;
  logic [bpar_pkg::BIT_W-1:0]     first_idx;
  logic                           hit;
  logic [bpar_pkg::PAGE_W-1:0]    cur_page;
  logic [bpar_pkg::PAGE_W-1:0]    st;
  logic [bpar_pkg::LEN_W-1:0]     new_len;

  // One step covers the run of equal bits that begins at bit_pos; it
  // ends at the first opposite bit or at the end of the word.
  always_comb begin
    is_free   = ~word[bit_pos];
    shifted   = word >> bit_pos;
    probe     = is_free ? shifted : ~shifted;
    hit       = 1'b0;
    first_idx = '0;
    for (int i = bpar_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (probe[i]) begin
        hit       = 1'b1;
        first_idx = bpar_pkg::BIT_W'(i);
      end
    end
    res.step = hit ? {1'b0, first_idx}
                   : bpar_pkg::STEP_W'(bpar_pkg::WORD_BITS) - {1'b0, bit_pos};
    cur_page  = {word_idx, bit_pos};
    st        = (run_len == '0) ? cur_page : run_start;
    new_len   = run_len + bpar_pkg::LEN_W'(res.step);
    res.found = is_free && (new_len >= {1'b0, need});
    res.len   = is_free ? new_len : '0;
    res.start = is_free ? st : run_start;
  end

endmodule

>>> rtl/bitmap_page_allocator_refcount_top.sv
// Page frame allocator with a one-bit-per-page bitmap and a 16-bit reference
// count per page, both held in RAMs with one read and one write port, driven
// by one sequencer that takes a single transaction at a time. After reset the
// block sweeps both stores clear, one page a cycle, before it takes the first
// transaction; init performs the same sweep but marks the first reserved
// pages (at most 32768) used with a reference count of one, then gives its
// result. Allocation walks the bitmap with one run-finding unit: each word is
// read, then stepped through one run of equal bits at a time, and the found
// run is then marked page by page. Free handles one page at a time (read,
// then update); incref and query read the page and then check it. Each
// transaction yields exactly one result, held in an output register.
`include "bitmap_page_allocator_refcount_top_macros.svh"

module bitmap_page_allocator_refcount_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [19:0] page,
  input  logic [15:0] count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [14:0] run_base,
  output logic [15:0] ref_count,
  output logic [15:0] free_count,
  output logic [14:0] fault_page
);

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_SCAN_RD  = 10'b0000000100,
    S_SCAN     = 10'b0000001000,
    S_MARK     = 10'b0000010000,
    S_FREE_RD  = 10'b0000100000,
    S_FREE_CHK = 10'b0001000000,
    S_REF_RD   = 10'b0010000000,
    S_REF_CHK  = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t                            state;
  logic [15:0]                       reserved;
  logic [15:0]                       limit;
  logic [bpar_pkg::PAGE_W-1:0]       sweep;
  logic                              init_pend;
  logic [2:0]                        func_r;
  logic [bpar_pkg::CNT_W-1:0]        count_r;
  logic [bpar_pkg::PIDX_W-1:0]       pidx;
  logic [bpar_pkg::CNT_W-1:0]        remaining;
  logic [bpar_pkg::WIDX_W-1:0]       w;
  logic [bpar_pkg::BIT_W-1:0]        b;
  logic [bpar_pkg::LEN_W-1:0]        run_len;
  logic [bpar_pkg::PAGE_W-1:0]       run_start;
  logic [15:0]                       free_total;
  logic [2:0]                        res_status;
  logic [14:0]                       res_start;
  logic [15:0]                       res_ref;
  logic [14:0]                       res_fault;

  bpar_pkg::store_wr_t               wr;
  bpar_pkg::scan_res_t               scan;
  logic [bpar_pkg::WIDX_W-1:0]       map_raddr;
  logic [bpar_pkg::WORD_BITS-1:0]    map_rdata;
  logic [bpar_pkg::REF_BITS-1:0]     ref_rdata;
  logic                              sweep_used;
  logic                              page_used;
  logic [bpar_pkg::STEP_W-1:0]       b_sum;
  logic [bpar_pkg::PIDX_W-1:0]       in_page_ext;

  bpar_store u_store (
    .clk       (clk),
    .wr        (wr),
    .map_raddr (map_raddr),
    .map_rdata (map_rdata),
    .ref_raddr (pidx[bpar_pkg::PAGE_W-1:0]),
    .ref_rdata (ref_rdata)
  );

  bpar_scan u_scan (
    .word      (map_rdata),
    .word_idx  (w),
    .bit_pos   (b),
    .run_len   (run_len),
    .run_start (run_start),
    .need      (count_r),
    .res       (scan)
  );

  assign in_stall    = (state != S_IDLE);
  assign sweep_used  = ({1'b0, sweep} < limit);
  assign page_used   = map_rdata[pidx[bpar_pkg::BIT_W-1:0]];
  assign b_sum       = {1'b0, b} + scan.step;
  assign in_page_ext = {1'b0, page};
  assign map_raddr   = (state == S_SCAN_RD || state == S_SCAN) ? w
                     : pidx[bpar_pkg::PAGE_W-1:bpar_pkg::BIT_W];

  always_comb begin
    wr = '0;
    case (state)
      S_CLEAR: begin
        wr.map_we    = 1'b1;
        wr.map_waddr = sweep[bpar_pkg::PAGE_W-1:bpar_pkg::BIT_W];
        wr.map_wbit  = sweep[bpar_pkg::BIT_W-1:0];
        wr.map_wval  = sweep_used;
        wr.ref_we    = 1'b1;
        wr.ref_waddr = sweep;
        wr.ref_wdata = bpar_pkg::REF_BITS'(sweep_used);
      end
      S_MARK: begin
        wr.map_we    = 1'b1;
        wr.map_waddr = pidx[bpar_pkg::PAGE_W-1:bpar_pkg::BIT_W];
        wr.map_wbit  = pidx[bpar_pkg::BIT_W-1:0];
        wr.map_wval  = 1'b1;
        wr.ref_we    = 1'b1;
        wr.ref_waddr = pidx[bpar_pkg::PAGE_W-1:0];
        wr.ref_wdata = bpar_pkg::REF_BITS'(1);
      end
      S_FREE_CHK: begin
        if (page_used && ref_rdata != '0) begin
          wr.ref_we    = 1'b1;
          wr.ref_waddr = pidx[bpar_pkg::PAGE_W-1:0];
          wr.ref_wdata = ref_rdata - bpar_pkg::REF_BITS'(1);
          wr.map_we    = (ref_rdata == bpar_pkg::REF_BITS'(1));
          wr.map_waddr = pidx[bpar_pkg::PAGE_W-1:bpar_pkg::BIT_W];
          wr.map_wbit  = pidx[bpar_pkg::BIT_W-1:0];
          wr.map_wval  = 1'b0;
        end
      end
      S_REF_CHK: begin
        if (func_r == bpar_pkg::FN_INCREF && page_used && ref_rdata != bpar_pkg::REF_MAX) begin
          wr.ref_we    = 1'b1;
          wr.ref_waddr = pidx[bpar_pkg::PAGE_W-1:0];
          wr.ref_wdata = ref_rdata + bpar_pkg::REF_BITS'(1);
        end
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else if (cfg_we) begin
      reserved <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      sweep      <= '0;
      limit      <= '0;
      init_pend  <= 1'b0;
      free_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          sweep <= sweep + bpar_pkg::PAGE_W'(1);
          if (sweep == bpar_pkg::PAGE_W'(bpar_pkg::NUM_PAGES - 1)) begin
            state <= init_pend ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_r     <= func;
            count_r    <= count;
            pidx       <= in_page_ext;
            remaining  <= count;
            w          <= '0;
            b          <= '0;
            run_len    <= '0;
            run_start  <= '0;
            res_status <= bpar_pkg::ST_OK;
            res_start  <= '0;
            res_ref    <= '0;
            res_fault  <= '0;
            case (func)
              bpar_pkg::FN_INIT: begin
                if (reserved > 16'(bpar_pkg::NUM_PAGES)) begin
                  limit      <= 16'(bpar_pkg::NUM_PAGES);
                  free_total <= '0;
                end else begin
                  limit      <= reserved;
                  free_total <= 16'(bpar_pkg::NUM_PAGES) - reserved;
                end
                sweep     <= '0;
                init_pend <= 1'b1;
                state     <= S_CLEAR;
              end
              bpar_pkg::FN_ALLOC: begin
                if (count == '0) begin
                  res_status <= bpar_pkg::ST_BAD_COUNT;
                  state      <= S_DONE;
                end else if (free_total < count) begin
                  res_status <= bpar_pkg::ST_NO_MEM;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              bpar_pkg::FN_FREE: begin
                if (count == '0) begin
                  res_status <= bpar_pkg::ST_BAD_COUNT;
                  state      <= S_DONE;
                end else begin
                  state <= S_FREE_RD;
                end
              end
              bpar_pkg::FN_INCREF, bpar_pkg::FN_QUERY: begin
                if (page >= 20'(bpar_pkg::NUM_PAGES)) begin
                  res_status <= bpar_pkg::ST_BAD_PAGE;
                  state      <= S_DONE;
                end else begin
                  state <= S_REF_RD;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          run_len   <= scan.len;
          run_start <= scan.start;
          if (scan.found) begin
            res_start  <= scan.start;
            pidx       <= bpar_pkg::PIDX_W'(scan.start);
            free_total <= free_total - count_r;
            state      <= S_MARK;
          end else if (b_sum[bpar_pkg::BIT_W]) begin
            if (w == bpar_pkg::WIDX_W'(bpar_pkg::MAP_WORDS - 1)) begin
              res_status <= bpar_pkg::ST_NO_MEM;
              state      <= S_DONE;
            end else begin
              w     <= w + bpar_pkg::WIDX_W'(1);
              b     <= '0;
              state <= S_SCAN_RD;
            end
          end else begin
            b <= b_sum[bpar_pkg::BIT_W-1:0];
          end
        end
        S_MARK: begin
          pidx      <= pidx + bpar_pkg::PIDX_W'(1);
          remaining <= remaining - bpar_pkg::CNT_W'(1);
          if (remaining == bpar_pkg::CNT_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_FREE_RD: begin
          if (pidx >= bpar_pkg::PIDX_W'(bpar_pkg::NUM_PAGES)) begin
            res_status <= bpar_pkg::ST_BAD_PAGE;
            res_fault  <= pidx[14:0];
            res_ref    <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_FREE_CHK;
          end
        end
        S_FREE_CHK: begin
          if (!page_used) begin
            res_status <= bpar_pkg::ST_DOUBLE_FREE;
            res_fault  <= pidx[14:0];
            res_ref    <= '0;
            state      <= S_DONE;
          end else if (ref_rdata == '0) begin
            res_status <= bpar_pkg::ST_BAD_REF;
            res_fault  <= pidx[14:0];
            res_ref    <= '0;
            state      <= S_DONE;
          end else begin
            res_ref <= ref_rdata - bpar_pkg::REF_BITS'(1);
            if (ref_rdata == bpar_pkg::REF_BITS'(1)) begin
              free_total <= free_total + 16'd1;
            end
            remaining <= remaining - bpar_pkg::CNT_W'(1);
            pidx      <= pidx + bpar_pkg::PIDX_W'(1);
            state     <= (remaining == bpar_pkg::CNT_W'(1)) ? S_DONE : S_FREE_RD;
          end
        end
        S_REF_RD: begin
          state <= S_REF_CHK;
        end
        S_REF_CHK: begin
          if (func_r == bpar_pkg::FN_QUERY) begin
            res_ref <= ref_rdata;
          end else if (!page_used) begin
            res_status <= bpar_pkg::ST_NOT_ALLOC;
          end else if (ref_rdata == bpar_pkg::REF_MAX) begin
            res_status <= bpar_pkg::ST_OVERFLOW;
            res_ref    <= ref_rdata;
          end else begin
            res_ref <= ref_rdata + bpar_pkg::REF_BITS'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // The result register frees up at this edge if it is being taken.
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            run_base   <= res_start;
            ref_count  <= res_ref;
            free_count <= free_total;
            fault_page <= res_fault;
            init_pend  <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BPAR_CHECK(a_state_onehot, $onehot(state))
  `BPAR_CHECK(a_free_bounded, free_total <= 16'(bpar_pkg::NUM_PAGES))
  `BPAR_CHECK(a_result_from_done, $rose(out_valid) |-> $past(state == S_DONE))
  `BPAR_CHECK(a_mark_has_work, (state == S_MARK) |-> (remaining != '0))

endmodule
